// ===== rtl/time_of_day_alarm_table_top_assert.svh =====
// Assertion macros for the alarm table block.
// Used by the sequencer; expects clk and rst_n in scope.
`ifndef TIME_OF_DAY_ALARM_TABLE_TOP_ASSERT_SVH
`define TIME_OF_DAY_ALARM_TABLE_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define TODAT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TODAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/todat_pkg.sv =====
// Shared types and constants of the alarm table block.
// No dependencies; used by the input interface and all modules.
package todat_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int POS_W = 4;

  // Item kinds
  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_DEL   = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;
  localparam logic [1:0] KIND_TIME  = 2'd3;

  // One stored alarm, 30 bits
  typedef struct packed {
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic        one_shot;
    logic        switch_on;
    logic        blink_mode;
    logic [15:0] blink_length;
  } entry_t;

  // One result beat
  typedef struct packed {
    logic        status;
    logic        fired;
    logic        do_switch_on;
    logic        do_blink;
    logic [15:0] blink_time;
    logic        last;
  } res_t;

  localparam res_t RES_NONE = '0;

  // Request to the compare unit
  typedef struct packed {
    logic       time_mode;
    logic       target;
    logic [4:0] hour;
    logic [5:0] minute;
  } cmp_req_t;

  // Verdict of the compare unit
  typedef struct packed {
    logic match;
    logic drop;
  } cmp_res_t;

endpackage

// ===== rtl/todat_if.sv =====
// Valid/ready channel interfaces of the alarm table block.
// Depends on todat_pkg for the field layout.
interface todat_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic        one_shot;
  logic        switch_on;
  logic        blink_mode;
  logic [15:0] blink_length;
  logic [todat_pkg::POS_W-1:0] position;

  modport source (output valid, kind, hour, minute, one_shot, switch_on, blink_mode,
                  blink_length, position, input ready);
  modport sink (input valid, kind, hour, minute, one_shot, switch_on, blink_mode,
                blink_length, position, output ready);
endinterface

interface todat_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic        fired;
  logic        do_switch_on;
  logic        do_blink;
  logic [15:0] blink_time;
  logic        last;

  modport source (output valid, status, fired, do_switch_on, do_blink, blink_time, last,
                  input ready);
  modport sink (input valid, status, fired, do_switch_on, do_blink, blink_time, last,
                output ready);
endinterface

// ===== rtl/todat_ram.sv =====
// Entry memory: one write port, one read port with registered read data.
// Depends on todat_pkg for the entry layout.
module todat_ram #(
  parameter int DEPTH = todat_pkg::TABLE_DEPTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  todat_pkg::entry_t   wdata,
  input  logic                re,
  input  logic [AW-1:0]       raddr,
  output todat_pkg::entry_t   rdata
);

  todat_pkg::entry_t mem [DEPTH];
  todat_pkg::entry_t rdata_r;

  // Write entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read entry, hold data while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/todat_cmp.sv =====
// Shared compare unit: decides whether the entry under the walk fires
// and whether it leaves the table. Depends on todat_pkg.
module todat_cmp (
  input  todat_pkg::entry_t   entry,
  input  todat_pkg::cmp_req_t req,
  output todat_pkg::cmp_res_t res
);

  logic hit;

  // Exact bit compare of hour and minute
  assign hit = (entry.hour == req.hour) && (entry.minute == req.minute);

  always_comb begin
    res.match = req.time_mode && hit;
    // A fired one-shot entry leaves; in delete mode the target leaves
    res.drop  = req.time_mode ? (hit && entry.one_shot) : req.target;
  end

endmodule

// ===== rtl/todat_seq.sv =====
// Sequencer of the alarm table: takes items, walks the table with
// compaction, holds the pending and output result. Depends on todat_pkg.
`include "time_of_day_alarm_table_top_assert.svh"
module todat_seq #(
  parameter int DEPTH = todat_pkg::TABLE_DEPTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  todat_in_if.sink             in_ch,
  todat_out_if.source          out_ch,
  output logic                 mem_we,
  output logic [AW-1:0]        mem_waddr,
  output todat_pkg::entry_t    mem_wdata,
  output logic                 mem_re,
  output logic [AW-1:0]        mem_raddr,
  input  todat_pkg::entry_t    mem_rdata,
  output todat_pkg::cmp_req_t  cmp_req,
  input  todat_pkg::cmp_res_t  cmp_res
);

  localparam int XW = (CW > todat_pkg::POS_W) ? CW : todat_pkg::POS_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_WALK  = 3'b010,
    S_FLUSH = 3'b100
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [CW-1:0]   rd_r, rd_nxt;
  logic [CW-1:0]   wr_r, wr_nxt;
  logic [CW-1:0]   pos_r, pos_nxt;
  logic            mode_r, mode_nxt;
  logic [4:0]      hour_r, hour_nxt;
  logic [5:0]      min_r, min_nxt;
  todat_pkg::res_t pend_r, pend_nxt;
  logic            pend_v_r, pend_v_nxt;
  todat_pkg::res_t out_r, out_nxt;
  logic            out_v_r, out_v_nxt;
  logic            out_free;
  logic            pos_bad;
  logic [CW-1:0]   pos_c;
  logic            full;

  assign out_free = !out_v_r || out_ch.ready;
  assign pos_bad  = XW'(in_ch.position) >= XW'(cnt_r);
  assign pos_c    = CW'(in_ch.position);
  assign full     = (cnt_r == DEPTH_C);

  assign in_ch.ready = (state_r == S_IDLE);

  // Compare request for the entry under the walk
  always_comb begin
    cmp_req.time_mode = mode_r;
    cmp_req.target    = (rd_r == pos_r);
    cmp_req.hour      = hour_r;
    cmp_req.minute    = min_r;
  end

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    rd_nxt     = rd_r;
    wr_nxt     = wr_r;
    pos_nxt    = pos_r;
    mode_nxt   = mode_r;
    hour_nxt   = hour_r;
    min_nxt    = min_r;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    out_nxt    = out_r;
    out_v_nxt  = out_v_r && !out_ch.ready;
    mem_we     = 1'b0;
    mem_waddr  = wr_r[AW-1:0];
    mem_wdata  = mem_rdata;
    mem_re     = 1'b0;
    mem_raddr  = rd_r[AW-1:0];
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          hour_nxt = in_ch.hour;
          min_nxt  = in_ch.minute;
          mode_nxt = (in_ch.kind == todat_pkg::KIND_TIME);
          pos_nxt  = pos_c;
          case (in_ch.kind)
            todat_pkg::KIND_ADD: begin
              // Append at the end unless full
              pend_nxt        = todat_pkg::RES_NONE;
              pend_nxt.status = full;
              pend_nxt.last   = 1'b1;
              pend_v_nxt      = 1'b1;
              if (!full) begin
                mem_we                 = 1'b1;
                mem_waddr              = cnt_r[AW-1:0];
                mem_wdata.hour         = in_ch.hour;
                mem_wdata.minute       = in_ch.minute;
                mem_wdata.one_shot     = in_ch.one_shot;
                mem_wdata.switch_on    = in_ch.switch_on;
                mem_wdata.blink_mode   = in_ch.blink_mode;
                mem_wdata.blink_length = in_ch.blink_length;
                cnt_nxt                = cnt_r + CW'(1);
              end
              state_nxt = S_FLUSH;
            end
            todat_pkg::KIND_CLEAR: begin
              cnt_nxt       = '0;
              pend_nxt      = todat_pkg::RES_NONE;
              pend_nxt.last = 1'b1;
              pend_v_nxt    = 1'b1;
              state_nxt     = S_FLUSH;
            end
            todat_pkg::KIND_DEL: begin
              if (pos_bad) begin
                pend_nxt        = todat_pkg::RES_NONE;
                pend_nxt.status = 1'b1;
                pend_nxt.last   = 1'b1;
                pend_v_nxt      = 1'b1;
                state_nxt       = S_FLUSH;
              end else begin
                // Compact from the deleted position onward
                rd_nxt     = pos_c;
                wr_nxt     = pos_c;
                mem_re     = 1'b1;
                mem_raddr  = pos_c[AW-1:0];
                pend_v_nxt = 1'b0;
                state_nxt  = S_WALK;
              end
            end
            default: begin
              // Time check walks the whole table
              rd_nxt     = '0;
              wr_nxt     = '0;
              mem_re     = 1'b1;
              mem_raddr  = '0;
              pend_v_nxt = 1'b0;
              state_nxt  = S_WALK;
            end
          endcase
        end
      end
      S_WALK: begin
        if (rd_r == cnt_r) begin
          // Walk done: new count, mark the final result
          cnt_nxt = wr_r;
          if (!pend_v_r) begin
            pend_nxt = todat_pkg::RES_NONE;
          end
          pend_nxt.last = 1'b1;
          pend_v_nxt    = 1'b1;
          state_nxt     = S_FLUSH;
        end else if (!(cmp_res.match && pend_v_r && !out_free)) begin
          if (cmp_res.match) begin
            // Push the earlier match out, hold the new one
            if (pend_v_r) begin
              out_v_nxt = 1'b1;
              out_nxt   = pend_r;
            end
            pend_nxt.status       = 1'b0;
            pend_nxt.fired        = 1'b1;
            pend_nxt.do_switch_on = mem_rdata.switch_on;
            pend_nxt.do_blink     = mem_rdata.blink_mode;
            pend_nxt.blink_time   = mem_rdata.blink_length;
            pend_nxt.last         = 1'b0;
            pend_v_nxt            = 1'b1;
          end
          // Keep the entry: write it back at the compacted slot
          if (!cmp_res.drop) begin
            mem_we    = 1'b1;
            mem_waddr = wr_r[AW-1:0];
            mem_wdata = mem_rdata;
            wr_nxt    = wr_r + CW'(1);
          end
          rd_nxt    = rd_r + CW'(1);
          mem_re    = 1'b1;
          mem_raddr = rd_nxt[AW-1:0];
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          out_v_nxt  = 1'b1;
          out_nxt    = pend_r;
          pend_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  // Payload and walk registers
  always_ff @(posedge clk) begin
    rd_r   <= rd_nxt;
    wr_r   <= wr_nxt;
    pos_r  <= pos_nxt;
    mode_r <= mode_nxt;
    hour_r <= hour_nxt;
    min_r  <= min_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.status       = out_r.status;
  assign out_ch.fired        = out_r.fired;
  assign out_ch.do_switch_on = out_r.do_switch_on;
  assign out_ch.do_blink     = out_r.do_blink;
  assign out_ch.blink_time   = out_r.blink_time;
  assign out_ch.last         = out_r.last;

  `TODAT_ASSERT_NEXT(a_busy, in_ch.valid && in_ch.ready, !in_ch.ready, "not busy after accept")
  `TODAT_ASSERT_SAME(a_count_bound, 1'b1, cnt_r <= DEPTH_C, "entry count beyond table depth")
  `TODAT_ASSERT_SAME(a_walk, state_r == S_WALK, wr_r <= rd_r && rd_r <= cnt_r, "walk out of order")
  `TODAT_ASSERT_SAME(a_flush_pending, state_r == S_FLUSH, pend_v_r, "flush with no result")

endmodule

// ===== rtl/time_of_day_alarm_table_top.sv =====
// Alarm table top: add, delete, clear and time check over one entry memory.
// Add, clear and failed delete set a pending beat, sent out from the flush state.
// Delete walks from its position and time check from the start, one entry a cycle
// from one memory read port, unless a second match waits on a stalled output.
// Only one item is taken at a time; a new one waits until the block is idle.
// Reset (rst_n low, synchronous) empties the table; no clearing pass.
module time_of_day_alarm_table_top #(
  parameter int TABLE_DEPTH = todat_pkg::TABLE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  todat_in_if.sink      in_ch,
  todat_out_if.source   out_ch
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  todat_pkg::entry_t   mem_wdata;
  logic                mem_re;
  logic [AW-1:0]       mem_raddr;
  todat_pkg::entry_t   mem_rdata;
  todat_pkg::cmp_req_t cmp_req;
  todat_pkg::cmp_res_t cmp_res;

  todat_ram #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  todat_cmp u_cmp (
    .entry (mem_rdata),
    .req   (cmp_req),
    .res   (cmp_res)
  );

  todat_seq #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .cmp_req   (cmp_req),
    .cmp_res   (cmp_res)
  );

endmodule

// ===== tb/time_of_day_alarm_table_top_test.sv =====
`timescale 1ns / 100ps
// Testbench for the alarm table block: directed and random add, delete, clear and
// time-check beats, with results checked against a shadow copy of the table.
// Depends on todat_pkg, todat_if and time_of_day_alarm_table_top.
module time_of_day_alarm_table_top_test;

  localparam int DEPTH = todat_pkg::TABLE_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 500000;

  // One request beat as the driver builds it
  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic        one_shot;
    logic        switch_on;
    logic        blink_mode;
    logic [15:0] blink_length;
    logic [3:0]  position;
  } alarm_req_t;

  // Shadow of the alarm table and the queue of result beats it predicts
  class alarm_table_shadow;
    todat_pkg::entry_t slots[DEPTH];
    int unsigned       used;
    todat_pkg::res_t   pending_beats[$];
    int                errors;

    function new();
      used = 0;
      errors = 0;
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    // Append one predicted beat
    function void queue_beat(todat_pkg::res_t b);
      pending_beats = {pending_beats, b};
    endfunction

    // Apply one accepted request and queue the beats it should produce
    function void note_request(alarm_req_t r);
      todat_pkg::res_t b;
      int unsigned i;
      int unsigned j;
      int hits;
      b = todat_pkg::RES_NONE;
      b.last = 1'b1;
      hits = 0;
      case (r.kind)
        todat_pkg::KIND_ADD: begin
          if (used >= DEPTH) begin
            b.status = 1'b1;
          end else begin
            slots[used] = '{hour: r.hour, minute: r.minute, one_shot: r.one_shot,
                            switch_on: r.switch_on, blink_mode: r.blink_mode,
                            blink_length: r.blink_length};
            used++;
          end
          queue_beat(b);
        end
        todat_pkg::KIND_DEL: begin
          if (r.position >= used) begin
            b.status = 1'b1;
          end else begin
            for (j = r.position; j + 1 < used; j++) slots[j] = slots[j + 1];
            used--;
          end
          queue_beat(b);
        end
        todat_pkg::KIND_CLEAR: begin
          used = 0;
          queue_beat(b);
        end
        default: begin
          // Walk in order; a fired one-shot is removed and its slot is looked at again
          i = 0;
          while (i < used) begin
            if (slots[i].hour == r.hour && slots[i].minute == r.minute) begin
              b = todat_pkg::RES_NONE;
              b.fired = 1'b1;
              b.do_switch_on = slots[i].switch_on;
              b.do_blink = slots[i].blink_mode;
              b.blink_time = slots[i].blink_length;
              queue_beat(b);
              hits++;
            end
            if (slots[i].hour == r.hour && slots[i].minute == r.minute && slots[i].one_shot)
            begin
              for (j = i; j + 1 < used; j++) slots[j] = slots[j + 1];
              used--;
            end else begin
              i++;
            end
          end
          if (hits == 0) begin
            b = todat_pkg::RES_NONE;
            b.last = 1'b1;
            queue_beat(b);
          end else begin
            pending_beats[pending_beats.size() - 1].last = 1'b1;
          end
        end
      endcase
    endfunction

    // Compare one accepted result beat with the oldest prediction
    task check_beat(todat_pkg::res_t got);
      todat_pkg::res_t want;
      if (pending_beats.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing pending: %h", got));
        return;
      end
      want = pending_beats.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status %b, want %b", got.status, want.status));
      if (got.fired !== want.fired)
        report_mismatch($sformatf("fired %b, want %b", got.fired, want.fired));
      if (got.do_switch_on !== want.do_switch_on)
        report_mismatch($sformatf("do_switch_on %b, want %b", got.do_switch_on,
                                  want.do_switch_on));
      if (got.do_blink !== want.do_blink)
        report_mismatch($sformatf("do_blink %b, want %b", got.do_blink, want.do_blink));
      if (got.blink_time !== want.blink_time)
        report_mismatch($sformatf("blink_time %h, want %h", got.blink_time,
                                  want.blink_time));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %b, want %b", got.last, want.last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   cycle_count = 0;
  int   in_idle_pct = 0;
  int   out_idle_pct = 0;
  int   stall_left = 0;

  alarm_table_shadow shadow = new();

  todat_in_if  in_ch();
  todat_out_if out_ch();

  time_of_day_alarm_table_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        shadow.note_request('{kind: in_ch.kind, hour: in_ch.hour, minute: in_ch.minute,
                              one_shot: in_ch.one_shot, switch_on: in_ch.switch_on,
                              blink_mode: in_ch.blink_mode,
                              blink_length: in_ch.blink_length,
                              position: in_ch.position});
      if (out_ch.valid && out_ch.ready)
        shadow.check_beat('{status: out_ch.status, fired: out_ch.fired,
                            do_switch_on: out_ch.do_switch_on, do_blink: out_ch.do_blink,
                            blink_time: out_ch.blink_time, last: out_ch.last});
    end
  end

  // Drive result ready with random stall bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready = 1'b0;
    end else if (stall_left > 0) begin
      out_ch.ready = 1'b0;
      stall_left--;
    end else if (out_idle_pct > 0 && $urandom_range(0, 99) < out_idle_pct) begin
      out_ch.ready = 1'b0;
      stall_left = $urandom_range(1, 8) - 1;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  // Request with every field random; callers overwrite what matters
  function automatic alarm_req_t blank_req(logic [1:0] kind);
    alarm_req_t r;
    r.kind = kind;
    r.hour = 5'($urandom);
    r.minute = 6'($urandom);
    r.one_shot = 1'($urandom);
    r.switch_on = 1'($urandom);
    r.blink_mode = 1'($urandom);
    r.blink_length = 16'($urandom);
    r.position = 4'($urandom);
    return r;
  endfunction

  // Present one beat at a falling edge, hold until taken, then maybe idle
  task automatic drive_item(input alarm_req_t r);
    int gap;
    in_ch.kind = r.kind;
    in_ch.hour = r.hour;
    in_ch.minute = r.minute;
    in_ch.one_shot = r.one_shot;
    in_ch.switch_on = r.switch_on;
    in_ch.blink_mode = r.blink_mode;
    in_ch.blink_length = r.blink_length;
    in_ch.position = r.position;
    in_ch.valid = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    if (in_idle_pct > 0 && $urandom_range(0, 99) < in_idle_pct) begin
      gap = $urandom_range(1, 8);
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic add_alarm(logic [4:0] hour, logic [5:0] minute, logic one_shot,
                           logic switch_on, logic blink_mode, logic [15:0] blink_length);
    alarm_req_t r;
    r = blank_req(todat_pkg::KIND_ADD);
    r.hour = hour;
    r.minute = minute;
    r.one_shot = one_shot;
    r.switch_on = switch_on;
    r.blink_mode = blink_mode;
    r.blink_length = blink_length;
    drive_item(r);
  endtask

  task automatic delete_at(logic [3:0] position);
    alarm_req_t r;
    r = blank_req(todat_pkg::KIND_DEL);
    r.position = position;
    drive_item(r);
  endtask

  task automatic check_time(logic [4:0] hour, logic [5:0] minute);
    alarm_req_t r;
    r = blank_req(todat_pkg::KIND_TIME);
    r.hour = hour;
    r.minute = minute;
    drive_item(r);
  endtask

  task automatic clear_all_items();
    drive_item(blank_req(todat_pkg::KIND_CLEAR));
  endtask

  // One random beat, biased toward times that hit stored alarms
  task automatic random_item(int add_pct);
    alarm_req_t r;
    int roll;
    int unsigned cnt;
    int unsigned idx;
    cnt = shadow.used;
    roll = $urandom_range(0, 99);
    if (roll < add_pct) begin
      r = blank_req(todat_pkg::KIND_ADD);
      if ($urandom_range(0, 9) < 7) begin
        r.hour = 5'($urandom_range(0, 2));
        r.minute = 6'($urandom_range(0, 2));
      end
    end else if (roll < add_pct + 15) begin
      r = blank_req(todat_pkg::KIND_DEL);
      if (cnt > 0 && $urandom_range(0, 3) != 0) r.position = 4'($urandom_range(0, cnt - 1));
    end else if (roll < add_pct + 18) begin
      r = blank_req(todat_pkg::KIND_CLEAR);
    end else begin
      r = blank_req(todat_pkg::KIND_TIME);
      if (cnt > 0 && $urandom_range(0, 9) < 7) begin
        idx = $urandom_range(0, cnt - 1);
        r.hour = shadow.slots[idx].hour;
        r.minute = shadow.slots[idx].minute;
      end else if ($urandom_range(0, 1) == 0) begin
        r.hour = 5'($urandom_range(0, 2));
        r.minute = 6'($urandom_range(0, 2));
      end
    end
    drive_item(r);
  endtask

  initial begin
    int k;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind = todat_pkg::KIND_ADD;
    in_ch.hour = '0;
    in_ch.minute = '0;
    in_ch.one_shot = 1'b0;
    in_ch.switch_on = 1'b0;
    in_ch.blink_mode = 1'b0;
    in_ch.blink_length = '0;
    in_ch.position = '0;
    out_ch.ready = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty table, full table, out-of-range times, one-shot runs
    in_idle_pct = 20;
    out_idle_pct = 20;
    check_time(5'd0, 6'd0);
    delete_at(4'd0);
    for (k = 0; k < DEPTH; k++)
      add_alarm(5'd31, 6'd63, (k >= 2 && k <= 4) || k == 9 || k == 15, k[0], k[1],
                (k == 0) ? 16'h0000 : (k == 1) ? 16'hFFFF : 16'($urandom));
    add_alarm(5'd0, 6'd0, 1'b0, 1'b1, 1'b1, 16'hFFFF);
    check_time(5'd31, 6'd63);
    delete_at(4'd15);
    delete_at(4'd0);
    add_alarm(5'd0, 6'd0, 1'b1, 1'b1, 1'b0, 16'h8001);
    check_time(5'd0, 6'd0);
    check_time(5'd31, 6'd63);
    clear_all_items();
    check_time(5'd31, 6'd63);

    // Random phases with different idling on each side
    in_idle_pct = 25;
    out_idle_pct = 15;
    repeat (115) random_item(45);
    in_idle_pct = 0;
    out_idle_pct = 20;
    repeat (95) random_item(35);
    in_idle_pct = 30;
    out_idle_pct = 0;
    repeat (75) random_item(55);
    in_idle_pct = 0;
    out_idle_pct = 0;
    repeat (60) random_item(45);
    in_ch.valid = 1'b0;

    // Drain, then give the block time to show any extra beat
    while (shadow.pending_beats.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (shadow.pending_beats.size() != 0)
      shadow.report_mismatch($sformatf("%0d result beats never arrived",
                                       shadow.pending_beats.size()));
    if (shadow.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
